/* rtl/core/fba_pkg.sv */
`default_nettype none

package fba_pkg;

    localparam int MAX_FRAMES_DEF = 64;

    localparam int COUNT_W = 7;
    localparam int FRAME_W = 6;
    localparam int STATUS_W = 2;

    localparam logic FUNC_RESERVE = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

    typedef struct packed {
        logic                latch_req;
        logic                load_work;
        logic                scan_step;
        logic                emit_step;
        logic                out_single;
        logic                release_clear;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic count_zero;
        logic in_range;
        logic cnt_done;
        logic work_empty;
        logic emit_last;
        logic slot_free;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/core/fba_ctrl.sv */
`default_nettype none

module fba_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    input  wire fba_pkg::t_stat i_stat,
    output fba_pkg::t_cmd  o_cmd
);
    import fba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.status = ST_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_req = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.func == FUNC_RELEASE || i_stat.count_zero) begin
                    // Single-result requests wait here until the output register frees up.
                    if (i_stat.slot_free) begin
                        o_cmd.out_single    = 1'b1;
                        o_cmd.status        = (i_stat.func == FUNC_RELEASE && !i_stat.in_range)
                                              ? ST_RANGE : ST_OK;
                        o_cmd.release_clear = (i_stat.func == FUNC_RELEASE) && i_stat.in_range;
                        n_state             = S_IDLE;
                    end
                end else begin
                    o_cmd.load_work = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.cnt_done) begin
                    n_state = S_EMIT;
                end else if (i_stat.work_empty) begin
                    if (i_stat.slot_free) begin
                        o_cmd.out_single = 1'b1;
                        o_cmd.status     = ST_NOFREE;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/fba_dp.sv */
`default_nettype none

module fba_dp #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire [fba_pkg::COUNT_W-1:0]    i_frames_in_use,
    input  wire                           i_func,
    input  wire [fba_pkg::COUNT_W-1:0]    i_frame_count,
    input  wire [fba_pkg::FRAME_W-1:0]    i_frame_index,
    input  wire fba_pkg::t_cmd            i_cmd,
    output fba_pkg::t_stat                o_stat,
    input  wire                           i_out_ready,
    output logic                          o_out_valid,
    output logic [fba_pkg::FRAME_W-1:0]   o_frame_number,
    output logic                          o_granted,
    output logic [fba_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);
    import fba_pkg::*;

    localparam int MAP_W = (MAX_FRAMES < 64) ? MAX_FRAMES : 64;
    localparam int IDX_W = $clog2(MAP_W);

    logic [MAP_W-1:0]   r_map;
    logic [MAP_W-1:0]   r_work;
    logic [MAP_W-1:0]   r_pick;
    logic [COUNT_W-1:0] r_cnt;
    logic               r_func;
    logic [COUNT_W-1:0] r_count;
    logic [FRAME_W-1:0] r_index;

    logic               r_ovalid;
    logic [FRAME_W-1:0] r_ofr;
    logic               r_ogr;
    logic [STATUS_W-1:0] r_ost;
    logic               r_olast;

    logic [COUNT_W-1:0] active;
    logic [MAP_W-1:0]   act_mask;
    logic [MAP_W-1:0]   work_low;
    logic [MAP_W-1:0]   pick_low;
    logic [MAP_W-1:0]   rel_mask;
    logic               slot_free;

    function automatic logic [IDX_W-1:0] f_enc(input logic [MAP_W-1:0] v);
        logic [IDX_W-1:0] e;
        e = '0;
        for (int k = 0; k < MAP_W; k++) begin
            if (v[k]) begin
                e = e | IDX_W'(k);
            end
        end
        return e;
    endfunction

    assign active = (i_frames_in_use > COUNT_W'(MAP_W)) ? COUNT_W'(MAP_W) : i_frames_in_use;

    always_comb begin
        for (int i = 0; i < MAP_W; i++) begin
            act_mask[i] = (COUNT_W'(i) < active);
        end
    end

    // Isolate the lowest set bit of each vector.
    assign work_low  = r_work & (~r_work + MAP_W'(1));
    assign pick_low  = r_pick & (~r_pick + MAP_W'(1));
    assign rel_mask  = MAP_W'(1) << r_index[IDX_W-1:0];
    assign slot_free = !r_ovalid || i_out_ready;

    assign o_stat.func       = r_func;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.in_range   = ({1'b0, r_index} < active);
    assign o_stat.cnt_done   = (r_cnt == r_count);
    assign o_stat.work_empty = (r_work == '0);
    assign o_stat.emit_last  = (r_cnt == COUNT_W'(1));
    assign o_stat.slot_free  = slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_cmd.release_clear) begin
            r_map <= r_map & ~rel_mask;
        end else if (i_cmd.emit_step) begin
            r_map <= r_map | pick_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_func  <= i_func;
            r_count <= i_frame_count;
            r_index <= i_frame_index;
        end
        if (i_cmd.load_work) begin
            r_work <= ~r_map & act_mask;
            r_pick <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.scan_step) begin
            r_work <= r_work & ~work_low;
            r_pick <= r_pick | work_low;
            r_cnt  <= r_cnt + COUNT_W'(1);
        end else if (i_cmd.emit_step) begin
            r_pick <= r_pick & ~pick_low;
            r_cnt  <= r_cnt - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_single || i_cmd.emit_step) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_single) begin
            r_ofr   <= '0;
            r_ogr   <= 1'b0;
            r_ost   <= i_cmd.status;
            r_olast <= 1'b1;
        end else if (i_cmd.emit_step) begin
            r_ofr   <= FRAME_W'(f_enc(pick_low));
            r_ogr   <= 1'b1;
            r_ost   <= ST_OK;
            r_olast <= (r_cnt == COUNT_W'(1));
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_frame_number = r_ofr;
    assign o_granted      = r_ogr;
    assign o_status       = r_ost;
    assign o_last         = r_olast;

endmodule

`default_nettype wire

/* rtl/core/frame_bitmap_allocator_unit.sv */
// Release and zero-count requests are latched in IDLE and register their single result in
// DECODE once the output register is free; the next item is accepted only back in IDLE.
// A reserve of N frames runs N scan steps of the lowest-free-bit encoder to build the
// grant set, then N emit steps send one frame per cycle while the result stream is not stalled.
// A failing reserve scans all free active frames first.
// Synchronous active-low reset frees every frame and sets frames_in_use to 64.
`default_nettype none

module frame_bitmap_allocator_unit #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // APB configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [6:0] frame_count, [12:7] frame_index, [15:13] zero
    input  wire         s_tuser,   // [0] func
    // Result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [5:0] frame_number, [6] granted, [8:7] status, [15:9] zero
    output logic        m_tlast
);
    import fba_pkg::*;

    localparam logic [2:0] ADDR_FRAMES_IN_USE = 3'd0;

    logic [COUNT_W-1:0]  r_frames_in_use;
    t_cmd                cmd;
    t_stat               stat;
    logic [FRAME_W-1:0]  frame_number;
    logic                granted;
    logic [STATUS_W-1:0] status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= COUNT_W'(64);
        end else if (psel && penable && pwrite && paddr == ADDR_FRAMES_IN_USE) begin
            r_frames_in_use <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_FRAMES_IN_USE) ? 32'(r_frames_in_use) : 32'd0;

    fba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fba_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frames_in_use (r_frames_in_use),
        .i_func          (s_tuser),
        .i_frame_count   (s_tdata[6:0]),
        .i_frame_index   (s_tdata[12:7]),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_ready     (m_tready),
        .o_out_valid     (m_tvalid),
        .o_frame_number  (frame_number),
        .o_granted       (granted),
        .o_status        (status),
        .o_last          (m_tlast)
    );

    assign m_tdata = {7'd0, status, granted, frame_number};

endmodule

`default_nettype wire
